@@ design/ggcc_pkg.sv @@
`timescale 1ns / 1ps
package ggcc_pkg;

	// angle format
	localparam int SUBSECOND_BITS  = 11;
	localparam int SUB_FIELD_W     = 11;
	localparam int SUB_FIELD_SHIFT = SUB_FIELD_W - SUBSECOND_BITS;
	localparam int DEG_W           = 8;
	localparam int MIN_W           = 6;
	localparam int SEC_W           = 6;
	localparam int SEC_TOT_W       = 20;
	localparam int REM_W           = 12;
	localparam int MAG_W           = SEC_TOT_W + SUBSECOND_BITS;

	localparam int unsigned SEC_PER_MIN = 60;
	localparam int unsigned SEC_PER_DEG = 3600;
	localparam int unsigned SUB_PER_SEC = 1 << SUBSECOND_BITS;
	localparam int unsigned SUB_PER_MIN = SEC_PER_MIN * SUB_PER_SEC;
	localparam int unsigned SUB_PER_DEG = SEC_PER_DEG * SUB_PER_SEC;
	localparam int unsigned MAX_MAG     = 256 * SUB_PER_DEG - 1;

	// reciprocals for constant division, exact over the operand range
	localparam int DEG_RECIP_SHIFT = 32;
	localparam int DEG_RECIP_W     = 21;
	localparam longint unsigned DEG_RECIP =
		((64'd1 << DEG_RECIP_SHIFT) + SEC_PER_DEG - 1) / SEC_PER_DEG;
	localparam int DEG_PROD_W      = SEC_TOT_W + DEG_RECIP_W;

	localparam int MIN_RECIP_SHIFT = 18;
	localparam int MIN_RECIP_W     = 13;
	localparam longint unsigned MIN_RECIP =
		((64'd1 << MIN_RECIP_SHIFT) + SEC_PER_MIN - 1) / SEC_PER_MIN;
	localparam int MIN_PROD_W      = REM_W + MIN_RECIP_W;

	// request codes
	localparam logic REQ_ENCODE = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	localparam logic [5:0] PREC_RESET = 6'd32;

	// pipeline depth and per-stage load enables
	localparam int NSTAGE = 5;
	typedef logic [NSTAGE-1:0] stage_en_t;

	// place an axis code on the even bits
	function automatic logic [63:0] spread_bits(input logic [31:0] a);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			r[2*i] = a[i];
		end
		return r;
	endfunction

	// collect the even bits into an axis code
	function automatic logic [31:0] gather_bits(input logic [63:0] m);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = m[2*i];
		end
		return r;
	endfunction

	// keep the top prec bits, values above 32 keep all
	function automatic logic [31:0] prec_mask(input logic [5:0] prec);
		logic [31:0] m;
		for (int i = 0; i < 32; i++) begin
			m[i] = (int'(prec) + i >= 32);
		end
		return m;
	endfunction

endpackage

@@ design/ggcc_enc_axis.sv @@
`timescale 1ns / 1ps
module ggcc_enc_axis (
	input  logic                  clk,
	input  ggcc_pkg::stage_en_t   en,
	input  logic signed [31:0]    angle,
	input  logic [5:0]            precision,
	output logic [31:0]           code
);
	import ggcc_pkg::*;

	logic [31:0]            abs_c;
	logic [MAG_W-1:0]       mag_c;
	logic [DEG_PROD_W-1:0]  deg_prod_c;
	logic [SEC_TOT_W-1:0]   deg_sec_c;
	logic [SEC_TOT_W-1:0]   rem_c;
	logic [MIN_PROD_W-1:0]  min_prod_c;
	logic [REM_W-1:0]       sec_c;
	logic [SUB_FIELD_W-1:0] sub_field_c;
	logic [31:0]            code_c;

	logic                      neg_s1, neg_s2, neg_s3, neg_s4;
	logic [SUBSECOND_BITS-1:0] sub_s1, sub_s2, sub_s3, sub_s4;
	logic [SEC_TOT_W-1:0]      sec_tot_s1, sec_tot_s2;
	logic [DEG_W-1:0]          deg_s2, deg_s3, deg_s4;
	logic [REM_W-1:0]          rem_s3, rem_s4;
	logic [MIN_W-1:0]          min_s4;
	logic [31:0]               code_s5;

	// stage 1: magnitude with saturation
	always_comb begin
		abs_c = angle[31] ? (32'd0 - $unsigned(angle)) : $unsigned(angle);
		mag_c = (abs_c > MAX_MAG) ? MAG_W'(MAX_MAG) : abs_c[MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s1     <= angle[31];
			sec_tot_s1 <= mag_c[MAG_W-1:SUBSECOND_BITS];
			sub_s1     <= mag_c[SUBSECOND_BITS-1:0];
		end
	end

	// stage 2: degrees by reciprocal multiply
	assign deg_prod_c = DEG_PROD_W'(sec_tot_s1) * DEG_PROD_W'(DEG_RECIP);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			neg_s2     <= neg_s1;
			sub_s2     <= sub_s1;
			sec_tot_s2 <= sec_tot_s1;
			deg_s2     <= deg_prod_c[DEG_RECIP_SHIFT +: DEG_W];
		end
	end

	// stage 3: seconds left within the degree
	always_comb begin
		deg_sec_c = SEC_TOT_W'(deg_s2) * SEC_TOT_W'(SEC_PER_DEG);
		rem_c     = sec_tot_s2 - deg_sec_c;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			neg_s3 <= neg_s2;
			sub_s3 <= sub_s2;
			deg_s3 <= deg_s2;
			rem_s3 <= rem_c[REM_W-1:0];
		end
	end

	// stage 4: minutes by reciprocal multiply
	assign min_prod_c = MIN_PROD_W'(rem_s3) * MIN_PROD_W'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			neg_s4 <= neg_s3;
			sub_s4 <= sub_s3;
			deg_s4 <= deg_s3;
			rem_s4 <= rem_s3;
			min_s4 <= min_prod_c[MIN_RECIP_SHIFT +: MIN_W];
		end
	end

	// stage 5: seconds, pack fields and apply precision
	always_comb begin
		sec_c       = rem_s4 - REM_W'(min_s4) * REM_W'(SEC_PER_MIN);
		sub_field_c = SUB_FIELD_W'(sub_s4) << SUB_FIELD_SHIFT;
		code_c      = {neg_s4, deg_s4, min_s4, sec_c[SEC_W-1:0], sub_field_c};
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			code_s5 <= code_c & prec_mask(precision);
		end
	end

	assign code = code_s5;

endmodule

@@ design/ggcc_dec_axis.sv @@
`timescale 1ns / 1ps
module ggcc_dec_axis (
	input  logic                 clk,
	input  ggcc_pkg::stage_en_t  en,
	input  logic [31:0]          code,
	output logic signed [31:0]   angle
);
	import ggcc_pkg::*;

	logic [MAG_W:0]            sum_c;

	logic                      neg_s1, neg_s2, neg_s3;
	logic [DEG_W-1:0]          deg_s1;
	logic [MIN_W-1:0]          min_s1;
	logic [SEC_W-1:0]          sec_s1;
	logic [SUBSECOND_BITS-1:0] sub_s1;
	logic [MAG_W-1:0]          pd_s2, pm_s2, ps_s2;
	logic [MAG_W-1:0]          mag_s3;
	logic [31:0]               ang_s4, ang_s5;

	// stage 1: split fields
	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s1 <= code[31];
			deg_s1 <= code[30:23];
			min_s1 <= code[22:17];
			sec_s1 <= code[16:11];
			sub_s1 <= code[SUB_FIELD_W-1 -: SUBSECOND_BITS];
		end
	end

	// stage 2: scale each field to sub-second units
	always_ff @(posedge clk) begin
		if (en[1]) begin
			neg_s2 <= neg_s1;
			pd_s2  <= MAG_W'(deg_s1) * MAG_W'(SUB_PER_DEG);
			pm_s2  <= MAG_W'(min_s1) * MAG_W'(SUB_PER_MIN);
			ps_s2  <= MAG_W'({sec_s1, sub_s1});
		end
	end

	// stage 3: sum and saturate
	assign sum_c = (MAG_W+1)'(pd_s2) + (MAG_W+1)'(pm_s2) + (MAG_W+1)'(ps_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			neg_s3 <= neg_s2;
			mag_s3 <= (sum_c > MAX_MAG) ? MAG_W'(MAX_MAG) : sum_c[MAG_W-1:0];
		end
	end

	// stage 4: apply sign
	always_ff @(posedge clk) begin
		if (en[3]) begin
			ang_s4 <= neg_s3 ? (32'd0 - 32'(mag_s3)) : 32'(mag_s3);
		end
	end

	// stage 5: align with the encode path
	always_ff @(posedge clk) begin
		if (en[4]) begin
			ang_s5 <= ang_s4;
		end
	end

	assign angle = $signed(ang_s5);

endmodule

@@ design/geo_grid_code_convert.sv @@
`timescale 1ns / 1ps
// one transaction per cycle sustained while out_ready stays high
// the five register stages follow the encode chain of two constant reciprocal multiplies
// each stage loads when empty or when the next one moves, so bubbles close up under stall
// reset: arst_n clears all stage valid bits and sets precision to 32
// payload registers are not reset
module geo_grid_code_convert (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic signed [31:0]  lon_angle,
	input  logic signed [31:0]  lat_angle,
	input  logic [63:0]         grid_code_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         grid_code_out,
	output logic signed [31:0]  lon_angle_out,
	output logic signed [31:0]  lat_angle_out,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [5:0]          cfg_data
);
	import ggcc_pkg::*;

	stage_en_t          en;
	logic [NSTAGE-1:0]  vld_s;
	logic [NSTAGE-1:0]  vld_in;
	logic [NSTAGE-1:0]  req_s;
	logic [NSTAGE-1:0]  req_in;
	logic [5:0]         precision_q;
	logic [31:0]        lon_code_c, lat_code_c;
	logic [31:0]        lon_enc, lat_enc;
	logic signed [31:0] lon_dec, lat_dec;
	logic               req_last;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q <= PREC_RESET;
		end else if (cfg_valid) begin
			precision_q <= cfg_data;
		end
	end

	// per-stage ready chain from the output back
	always_comb begin
		logic nxt;
		nxt = out_ready;
		for (int k = NSTAGE - 1; k >= 0; k--) begin
			en[k] = !vld_s[k] || nxt;
			nxt   = en[k];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NSTAGE-1];
	assign vld_in    = {vld_s[NSTAGE-2:0], in_valid};
	assign req_in    = {req_s[NSTAGE-2:0], req_type};

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NSTAGE; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	// request type travels with the data
	always_ff @(posedge clk) begin
		for (int k = 0; k < NSTAGE; k++) begin
			if (en[k]) begin
				req_s[k] <= req_in[k];
			end
		end
	end

	// de-interleave the incoming grid code
	assign lon_code_c = gather_bits(grid_code_in);
	assign lat_code_c = gather_bits(grid_code_in >> 1);

	ggcc_enc_axis u_enc_lon (
		.clk       (clk),
		.en        (en),
		.angle     (lon_angle),
		.precision (precision_q),
		.code      (lon_enc)
	);

	ggcc_enc_axis u_enc_lat (
		.clk       (clk),
		.en        (en),
		.angle     (lat_angle),
		.precision (precision_q),
		.code      (lat_enc)
	);

	ggcc_dec_axis u_dec_lon (
		.clk   (clk),
		.en    (en),
		.code  (lon_code_c),
		.angle (lon_dec)
	);

	ggcc_dec_axis u_dec_lat (
		.clk   (clk),
		.en    (en),
		.code  (lat_code_c),
		.angle (lat_dec)
	);

	// result select and interleave
	assign req_last      = req_s[NSTAGE-1];
	assign grid_code_out = (req_last == REQ_ENCODE) ?
		(spread_bits(lon_enc) | (spread_bits(lat_enc) << 1)) : 64'd0;
	assign lon_angle_out = (req_last == REQ_DECODE) ? lon_dec : 32'sd0;
	assign lat_angle_out = (req_last == REQ_DECODE) ? lat_dec : 32'sd0;

`ifndef SYNTHESIS
	// any empty stage or a taken result lets a new transaction in
	assert property (@(posedge clk) disable iff (!arst_n)
		(!(&vld_s) || out_ready) |-> in_ready)
		else $error("input stalled while the pipeline has room");

	// an accepted transaction occupies the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s[0])
		else $error("accepted transaction lost at stage 1");

	// decoded angles stay within the encodable range
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && req_last == REQ_DECODE) |->
		(int'(lon_angle_out) <= int'(MAX_MAG)) && (int'(lon_angle_out) >= -int'(MAX_MAG)) &&
		(int'(lat_angle_out) <= int'(MAX_MAG)) && (int'(lat_angle_out) >= -int'(MAX_MAG)))
		else $error("decoded angle out of range");

	// a configuration write lands in the precision register
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> precision_q == $past(cfg_data))
		else $error("precision write not taken");
`endif

endmodule

@@ test/geo_grid_code_convert_chk.sv @@
`timescale 1ns / 1ps
module geo_grid_code_convert_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               req_type,
	input  logic signed [31:0] lon_angle,
	input  logic signed [31:0] lat_angle,
	input  logic [63:0]        grid_code_in,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [63:0]        grid_code_out,
	input  logic signed [31:0] lon_angle_out,
	input  logic signed [31:0] lat_angle_out,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [5:0]         cfg_data,
	output int                 fail_count,
	output int                 pending
);
	import ggcc_pkg::*;

	typedef struct packed {
		logic [63:0] grid;
		logic [31:0] lon;
		logic [31:0] lat;
	} conversion_t;

	conversion_t pending_conversions[$];
	logic [5:0]  kept_bits = PREC_RESET;

	// angle to sign/deg/min/sec/sub axis code, cut to the leading bits kept
	function automatic logic [31:0] axis_code_from_angle(input logic [31:0] angle,
			input logic [5:0] prec);
		logic        neg;
		logic [31:0] mag;
		logic [31:0] rest;
		logic [31:0] deg;
		logic [31:0] mins;
		logic [31:0] secs;
		logic [31:0] sub;
		logic [31:0] code;
		logic [31:0] keep;
		int unsigned nkeep;
		neg = angle[31];
		mag = neg ? 32'd0 - angle : angle;
		if (mag > MAX_MAG)
			mag = MAX_MAG;
		deg  = mag / SUB_PER_DEG;
		rest = mag % SUB_PER_DEG;
		mins = rest / SUB_PER_MIN;
		rest = rest % SUB_PER_MIN;
		secs = rest / SUB_PER_SEC;
		sub  = rest % SUB_PER_SEC;
		code = {neg, deg[7:0], mins[5:0], secs[5:0], 11'(sub << SUB_FIELD_SHIFT)};
		nkeep = (prec > 6'd32) ? 32 : int'(prec);
		keep = 32'(64'hFFFF_FFFF_FFFF_FFFF << (32 - nkeep));
		return code & keep;
	endfunction

	// axis code back to a signed angle, fields at face value
	function automatic logic [31:0] angle_from_axis_code(input logic [31:0] code);
		logic [31:0] mag;
		mag = 32'(code[30:23]) * SUB_PER_DEG + 32'(code[22:17]) * SUB_PER_MIN +
			32'(code[16:11]) * SUB_PER_SEC + (32'(code[10:0]) >> SUB_FIELD_SHIFT);
		if (mag > MAX_MAG)
			mag = MAX_MAG;
		return code[31] ? 32'd0 - mag : mag;
	endfunction

	// move the 32 bits of a to the even positions
	function automatic logic [63:0] spread_even(input logic [31:0] a);
		logic [63:0] x;
		x = {32'd0, a};
		x = (x | (x << 16)) & 64'h0000_FFFF_0000_FFFF;
		x = (x | (x << 8))  & 64'h00FF_00FF_00FF_00FF;
		x = (x | (x << 4))  & 64'h0F0F_0F0F_0F0F_0F0F;
		x = (x | (x << 2))  & 64'h3333_3333_3333_3333;
		x = (x | (x << 1))  & 64'h5555_5555_5555_5555;
		return x;
	endfunction

	// collect the even positions into 32 bits
	function automatic logic [31:0] pick_even(input logic [63:0] m);
		logic [63:0] x;
		x = m & 64'h5555_5555_5555_5555;
		x = (x | (x >> 1))  & 64'h3333_3333_3333_3333;
		x = (x | (x >> 2))  & 64'h0F0F_0F0F_0F0F_0F0F;
		x = (x | (x >> 4))  & 64'h00FF_00FF_00FF_00FF;
		x = (x | (x >> 8))  & 64'h0000_FFFF_0000_FFFF;
		x = (x | (x >> 16)) & 64'h0000_0000_FFFF_FFFF;
		return x[31:0];
	endfunction

	function automatic conversion_t convert_request(input logic req,
			input logic [31:0] lon, input logic [31:0] lat,
			input logic [63:0] code, input logic [5:0] prec);
		conversion_t r;
		r = '0;
		if (req == REQ_ENCODE) begin
			r.grid = spread_even(axis_code_from_angle(lon, prec)) |
				(spread_even(axis_code_from_angle(lat, prec)) << 1);
		end else begin
			r.lon = angle_from_axis_code(pick_even(code));
			r.lat = angle_from_axis_code(pick_even(code >> 1));
		end
		return r;
	endfunction

	// compare results, queue predictions, track the precision register
	always @(posedge clk or negedge arst_n) begin : watch
		conversion_t want;
		if (!arst_n) begin
			kept_bits = PREC_RESET;
			pending_conversions.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_conversions.size() == 0) begin
					$error("result transaction with no conversion pending");
					fail_count++;
				end else begin
					want = pending_conversions.pop_front();
					if (grid_code_out !== want.grid) begin
						$error("grid_code_out: expected %h, got %h", want.grid, grid_code_out);
						fail_count++;
					end
					if (lon_angle_out !== want.lon) begin
						$error("lon_angle_out: expected %h, got %h", want.lon, lon_angle_out);
						fail_count++;
					end
					if (lat_angle_out !== want.lat) begin
						$error("lat_angle_out: expected %h, got %h", want.lat, lat_angle_out);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				pending_conversions.push_back(convert_request(req_type, lon_angle,
					lat_angle, grid_code_in, kept_bits));
			if (cfg_valid && cfg_ready)
				kept_bits = cfg_data;
			pending = pending_conversions.size();
		end
	end

endmodule

@@ test/geo_grid_code_convert_tb.sv @@
`timescale 1ns / 1ps
module geo_grid_code_convert_tb;
	import ggcc_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic signed [31:0] lon_angle;
	logic signed [31:0] lat_angle;
	logic [63:0]        grid_code_in;
	logic               out_valid;
	logic               out_ready;
	logic [63:0]        grid_code_out;
	logic signed [31:0] lon_angle_out;
	logic signed [31:0] lat_angle_out;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [5:0]         cfg_data;
	int                 fail_count;
	int                 pending;
	logic               sender_eager;
	logic               hold_output;

	geo_grid_code_convert dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.lon_angle     (lon_angle),
		.lat_angle     (lat_angle),
		.grid_code_in  (grid_code_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.grid_code_out (grid_code_out),
		.lon_angle_out (lon_angle_out),
		.lat_angle_out (lat_angle_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	geo_grid_code_convert_chk chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.lon_angle     (lon_angle),
		.lat_angle     (lat_angle),
		.grid_code_in  (grid_code_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.grid_code_out (grid_code_out),
		.lon_angle_out (lon_angle_out),
		.lat_angle_out (lat_angle_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end

	// lon on even bits, lat on odd bits
	function automatic logic [63:0] weave_axes(input logic [31:0] lon_code,
			input logic [31:0] lat_code);
		logic [63:0] g;
		for (int i = 0; i < 32; i++) begin
			g[2*i]   = lon_code[i];
			g[2*i+1] = lat_code[i];
		end
		return g;
	endfunction

	// well-formed axis code: minutes and seconds below 60
	function automatic logic [31:0] random_axis_code();
		return {1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
			11'($urandom_range(0, 2047))};
	endfunction

	function automatic logic [31:0] random_angle();
		logic [31:0] a;
		int          sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0: a = $urandom;
			// straddle the saturation point
			1: a = MAX_MAG - 2 + $urandom_range(0, 4);
			2: a = $urandom_range(0, 200000);
			default: a = $urandom_range(0, 2 * MAX_MAG) - MAX_MAG;
		endcase
		if ((sel == 1 || sel == 2) && $urandom_range(0, 1))
			a = 32'd0 - a;
		return a;
	endfunction

	// one input transaction, after a random gap unless sender_eager is set
	task automatic offer(input logic req, input logic [31:0] lon, input logic [31:0] lat,
			input logic [63:0] code);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type     = req;
		lon_angle    = lon;
		lat_angle    = lat;
		grid_code_in = code;
		in_valid     = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic offer_random();
		logic [63:0] code;
		code = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
			weave_axes(random_axis_code(), random_axis_code());
		offer($urandom_range(0, 1) ? REQ_DECODE : REQ_ENCODE, random_angle(),
			random_angle(), code);
	endtask

	task automatic write_precision(input logic [5:0] value);
		cfg_data  = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// stop offering and wait for every result
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// receiver with random stalls and one long hold
	initial begin : receiver
		int   stall;
		int   nresults;
		logic rx_eager;
		logic output_held;
		out_ready   = 1'b0;
		nresults    = 0;
		rx_eager    = 1'b0;
		output_held = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (nresults % 40 == 0)
				rx_eager = ($urandom_range(0, 3) == 0);
			if (hold_output && !output_held) begin
				out_ready = 1'b0;
				repeat (64) @(negedge clk);
				output_held = 1'b1;
			end
			stall = rx_eager ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
			nresults++;
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		logic [5:0] settings [8];
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = REQ_ENCODE;
		lon_angle    = '0;
		lat_angle    = '0;
		grid_code_in = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		sender_eager = 1'b0;
		hold_output  = 1'b0;
		settings = '{6'd1, 6'd0, 6'd63, 6'd33, 6'd31, 6'd32, 6'd16, 6'd0};
		settings[7] = 6'($urandom_range(0, 63));
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed encodes at the reset precision
		offer(REQ_ENCODE, 32'd0, 32'd0, {$urandom, $urandom});
		offer(REQ_ENCODE, MAX_MAG, 32'd0 - MAX_MAG, {$urandom, $urandom});
		offer(REQ_ENCODE, 32'd0 - MAX_MAG, MAX_MAG, {$urandom, $urandom});
		// most negative input and largest positive both saturate
		offer(REQ_ENCODE, 32'h8000_0000, 32'h7FFF_FFFF, {$urandom, $urandom});
		offer(REQ_ENCODE, MAX_MAG + 1, 32'd0 - (MAX_MAG + 1), {$urandom, $urandom});
		offer(REQ_ENCODE, 32'hFFFF_FFFF, 32'd1, {$urandom, $urandom});
		offer(REQ_ENCODE, SUB_PER_SEC - 1, SUB_PER_SEC, {$urandom, $urandom});
		offer(REQ_ENCODE, SUB_PER_MIN - 1, SUB_PER_MIN, {$urandom, $urandom});
		offer(REQ_ENCODE, SUB_PER_DEG - 1, SUB_PER_DEG, {$urandom, $urandom});

		// directed decodes
		offer(REQ_DECODE, $urandom, $urandom, 64'd0);
		offer(REQ_DECODE, $urandom, $urandom, 64'hFFFF_FFFF_FFFF_FFFF);
		// sign bits only: negative zero on both axes
		offer(REQ_DECODE, $urandom, $urandom, 64'hC000_0000_0000_0000);
		offer(REQ_DECODE, $urandom, $urandom,
			weave_axes(32'h7FFF_FFFF, {1'b1, 8'd10, 6'd63, 6'd63, 11'd0}));
		offer(REQ_DECODE, $urandom, $urandom,
			weave_axes({1'b0, 8'd179, 6'd59, 6'd59, 11'd2047},
				{1'b1, 8'd89, 6'd30, 6'd0, 11'd1}));
		// minutes and seconds of 60 taken at face value, second one saturates
		offer(REQ_DECODE, $urandom, $urandom,
			weave_axes({1'b0, 8'd0, 6'd60, 6'd60, 11'd0},
				{1'b1, 8'd255, 6'd59, 6'd60, 11'd5}));
		offer(REQ_DECODE, $urandom, $urandom, {$urandom, $urandom});
		drain();

		// random phases over precision settings, long output hold in one
		for (int p = 0; p < 8; p++) begin
			write_precision(settings[p]);
			sender_eager = (p == 2) || ($urandom_range(0, 3) == 0);
			hold_output  = (p == 2);
			repeat (75) offer_random();
			drain();
		end

		repeat (16) @(negedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
